// ===== rtl/blink_rate_mode_controller_top_macros.svh =====
// Assertion macros for the blink rate mode controller.
`ifndef BLINK_RATE_MODE_CONTROLLER_TOP_MACROS_SVH
`define BLINK_RATE_MODE_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmc assertion failed");

// Next-cycle implication, checked outside reset.
`define BMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmc assertion failed");

`endif

// ===== rtl/bmc_pkg.sv =====
// Package: types and constants of the blink rate mode controller.
`timescale 1ns / 1ps
package bmc_pkg;

  typedef enum logic [1:0] {
    MODE_BLINK = 2'd0,
    MODE_SLEEP = 2'd1,
    MODE_ERROR = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_DEFAULT_RATE = 2'd0,
    REG_MIN_RATE     = 2'd1,
    REG_MAX_RATE     = 2'd2
  } reg_idx_t;

  localparam int unsigned RATE_W  = 4;
  localparam int unsigned PHASE_W = 9;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [RATE_W-1:0] DEFAULT_RATE_RESET = 4'd2;
  localparam logic [RATE_W-1:0] MIN_RATE_RESET     = 4'd1;
  localparam logic [RATE_W-1:0] MAX_RATE_RESET     = 4'd5;
  localparam logic [RATE_W-1:0] RATE_TOP           = 4'd15;

  typedef struct packed {
    logic [RATE_W-1:0] default_rate;
    logic [RATE_W-1:0] min_rate;
    logic [RATE_W-1:0] max_rate;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic sleep_press;
    logic up_press;
    logic down_press;
    logic reset_press;
  } item_t;

  typedef struct packed {
    logic              pump_led;
    logic              horn_lamp;
    logic              fault_lamp;
    logic              pulse_lamp;
    mode_t             mode;
    logic [RATE_W-1:0] rate;
  } result_t;

endpackage

// ===== rtl/bmc_in_if.sv =====
// Input channel interface: tick and button flags.
`timescale 1ns / 1ps
interface bmc_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic sleep_press;
  logic up_press;
  logic down_press;
  logic reset_press;

  modport source (output valid, output tick, output sleep_press, output up_press,
                  output down_press, output reset_press, input ready);
  modport sink (input valid, input tick, input sleep_press, input up_press,
                input down_press, input reset_press, output ready);
endinterface

// ===== rtl/bmc_out_if.sv =====
// Output channel interface: indicator states, mode and rate.
`timescale 1ns / 1ps
interface bmc_out_if;
  logic       valid;
  logic       ready;
  logic       pump_led;
  logic       horn_lamp;
  logic       fault_lamp;
  logic       pulse_lamp;
  logic [1:0] mode;
  logic [3:0] rate;

  modport source (output valid, output pump_led, output horn_lamp, output fault_lamp,
                  output pulse_lamp, output mode, output rate, input ready);
  modport sink (input valid, input pump_led, input horn_lamp, input fault_lamp,
                input pulse_lamp, input mode, input rate, output ready);
endinterface

// ===== rtl/bmc_cfg_regs.sv =====
// APB-style configuration registers: default, min and max rate.
`timescale 1ns / 1ps
module bmc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmc_pkg::PADDR_W-1:0]   paddr,
  input  logic [bmc_pkg::PDATA_W-1:0]   pwdata,
  output logic [bmc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output bmc_pkg::cfg_t                 cfg
);

  bmc_pkg::cfg_t    cfg_next;
  bmc_pkg::reg_idx_t idx;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = bmc_pkg::reg_idx_t'(paddr[3:2]);

  always_comb begin
    cfg_next = cfg;
    prdata   = '0;
    unique case (idx)
      bmc_pkg::REG_DEFAULT_RATE: begin
        prdata = {28'd0, cfg.default_rate};
        if (wr) cfg_next.default_rate = pwdata[3:0];
      end
      bmc_pkg::REG_MIN_RATE: begin
        prdata = {28'd0, cfg.min_rate};
        if (wr) cfg_next.min_rate = pwdata[3:0];
      end
      bmc_pkg::REG_MAX_RATE: begin
        prdata = {28'd0, cfg.max_rate};
        if (wr) cfg_next.max_rate = pwdata[3:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_rate <= bmc_pkg::DEFAULT_RATE_RESET;
      cfg.min_rate     <= bmc_pkg::MIN_RATE_RESET;
      cfg.max_rate     <= bmc_pkg::MAX_RATE_RESET;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// ===== rtl/bmc_core.sv =====
// Mode, rate, phase and heartbeat state with its single-pass update.
`timescale 1ns / 1ps
module bmc_core #(
  parameter int unsigned TICKS_PER_SECOND   = 1000,
  parameter int unsigned HEARTBEAT_ON_TICKS = 250
) (
  input  logic              clk,
  input  logic              rst,
  input  bmc_pkg::cfg_t     cfg,
  input  logic              step,
  input  bmc_pkg::item_t    item,
  output bmc_pkg::result_t  result
);

  localparam int unsigned HBW = $clog2(TICKS_PER_SECOND);
  localparam int unsigned PW  = bmc_pkg::PHASE_W;
  localparam int unsigned RW  = bmc_pkg::RATE_W;

  // ticks per half period, indexed by rate; rate 0 uses rate 1
  localparam logic [PW-1:0] HALF_TBL [16] = '{
    PW'(TICKS_PER_SECOND / 2),  PW'(TICKS_PER_SECOND / 2),
    PW'(TICKS_PER_SECOND / 4),  PW'(TICKS_PER_SECOND / 6),
    PW'(TICKS_PER_SECOND / 8),  PW'(TICKS_PER_SECOND / 10),
    PW'(TICKS_PER_SECOND / 12), PW'(TICKS_PER_SECOND / 14),
    PW'(TICKS_PER_SECOND / 16), PW'(TICKS_PER_SECOND / 18),
    PW'(TICKS_PER_SECOND / 20), PW'(TICKS_PER_SECOND / 22),
    PW'(TICKS_PER_SECOND / 24), PW'(TICKS_PER_SECOND / 26),
    PW'(TICKS_PER_SECOND / 28), PW'(TICKS_PER_SECOND / 30)
  };

  bmc_pkg::mode_t  mode, mode_next;
  logic [RW-1:0]   rate, rate_next;
  logic [PW-1:0]   phase, phase_next;
  logic [PW-1:0]   saved, saved_next;
  logic            lit, lit_next;
  logic [HBW-1:0]  hb, hb_next;

  logic [RW:0]     r_up;
  logic [RW-1:0]   rate_a;
  logic [RW-1:0]   low;
  logic            err;
  logic [HBW:0]    hb_sum;

  always_comb begin
    mode_next  = mode;
    rate_next  = rate;
    phase_next = phase;
    saved_next = saved;
    lit_next   = lit;
    hb_next    = hb;
    err        = 1'b0;
    r_up       = {1'b0, rate} + (RW+1)'(1);
    rate_a     = rate;
    low        = (cfg.min_rate == '0) ? RW'(1) : cfg.min_rate;
    hb_sum     = {1'b0, hb} + (HBW+1)'(1);

    unique case (mode)
      bmc_pkg::MODE_BLINK: begin
        if (item.up_press) begin
          if (r_up > {1'b0, cfg.max_rate}) err = 1'b1;
          rate_a = r_up[RW] ? bmc_pkg::RATE_TOP : r_up[RW-1:0];
        end
        if (!err && item.down_press) begin
          if (rate_a == '0 || (rate_a - RW'(1)) < low) err = 1'b1;
          rate_a = (rate_a == '0) ? '0 : rate_a - RW'(1);
        end
        rate_next = rate_a;
        if (err) begin
          mode_next  = bmc_pkg::MODE_ERROR;
          saved_next = '0;
        end else begin
          if (item.up_press || item.down_press) phase_next = HALF_TBL[rate_a];
          if (item.reset_press) begin
            rate_next  = cfg.default_rate;
            phase_next = saved;
          end else if (item.sleep_press) begin
            saved_next = phase_next;
            mode_next  = bmc_pkg::MODE_SLEEP;
          end
        end
      end
      bmc_pkg::MODE_SLEEP: begin
        if (item.reset_press) begin
          rate_next  = cfg.default_rate;
          mode_next  = bmc_pkg::MODE_BLINK;
          phase_next = saved;
        end else if (item.sleep_press) begin
          mode_next  = bmc_pkg::MODE_BLINK;
          phase_next = saved;
        end
      end
      bmc_pkg::MODE_ERROR: begin
        if (item.reset_press) begin
          rate_next  = cfg.default_rate;
          mode_next  = bmc_pkg::MODE_BLINK;
          phase_next = saved;
        end
      end
      default: ;
    endcase

    if (item.tick) begin
      if (mode_next == bmc_pkg::MODE_BLINK) begin
        if (phase_next <= PW'(1)) begin
          lit_next   = ~lit;
          phase_next = HALF_TBL[rate_next];
        end else begin
          phase_next = phase_next - PW'(1);
        end
      end
      hb_next = (hb_sum >= (HBW+1)'(TICKS_PER_SECOND)) ? '0 : hb_sum[HBW-1:0];
    end

    result.pump_led   = (mode_next == bmc_pkg::MODE_BLINK) && lit_next;
    result.horn_lamp  = (mode_next == bmc_pkg::MODE_BLINK) && !lit_next;
    result.fault_lamp = (mode_next == bmc_pkg::MODE_ERROR);
    result.pulse_lamp = (32'(hb_next) < 32'(HEARTBEAT_ON_TICKS));
    result.mode       = mode_next;
    result.rate       = rate_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= bmc_pkg::MODE_BLINK;
      rate  <= bmc_pkg::DEFAULT_RATE_RESET;
      phase <= HALF_TBL[bmc_pkg::DEFAULT_RATE_RESET];
      saved <= '0;
      lit   <= 1'b1;
      hb    <= '0;
    end else if (step) begin
      mode  <= mode_next;
      rate  <= rate_next;
      phase <= phase_next;
      saved <= saved_next;
      lit   <= lit_next;
      hb    <= hb_next;
    end
  end

endmodule

// ===== rtl/bmc_out_reg.sv =====
// Result register driving the output channel.
`timescale 1ns / 1ps
module bmc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bmc_pkg::result_t  result,
  output logic              can_load,
  bmc_out_if.source         out_ch
);

  bmc_pkg::result_t data;
  logic             valid;

  assign can_load = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) data <= result;
  end

  assign out_ch.valid      = valid;
  assign out_ch.pump_led   = data.pump_led;
  assign out_ch.horn_lamp  = data.horn_lamp;
  assign out_ch.fault_lamp = data.fault_lamp;
  assign out_ch.pulse_lamp = data.pulse_lamp;
  assign out_ch.mode       = 2'(data.mode);
  assign out_ch.rate       = data.rate;

endmodule

// ===== rtl/blink_rate_mode_controller_top.sv =====
// Top level of the blink rate mode controller.
//
//   port      dir  beat contents
//   in_ch     in   tick, sleep_press, up_press, down_press, reset_press
//   out_ch    out  pump_led, horn_lamp, fault_lamp, pulse_lamp, mode, rate
//   apb       in   default_rate @0x0, min_rate @0x4, max_rate @0x8
//
// One beat per cycle sustained while out_ch is not stalled; an input beat passes the input
// register, then the state update into the result register, before it leaves as an output beat.
// Reset: synchronous; registers to their reset values, channels empty, no clearing pass.
// An output stall holds the result register, then the input register, then in_ch.ready.
`timescale 1ns / 1ps
`include "blink_rate_mode_controller_top_macros.svh"
module blink_rate_mode_controller_top #(
  parameter int unsigned TICKS_PER_SECOND   = 1000,
  parameter int unsigned HEARTBEAT_ON_TICKS = 250
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmc_pkg::PADDR_W-1:0]   paddr,
  input  logic [bmc_pkg::PDATA_W-1:0]   pwdata,
  output logic [bmc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  bmc_in_if.sink                        in_ch,
  bmc_out_if.source                     out_ch
);

  bmc_pkg::cfg_t    cfg;
  bmc_pkg::item_t   stage;
  bmc_pkg::result_t result;
  logic             stage_valid;
  logic             can_load;
  logic             step;

  assign step        = stage_valid && can_load;
  assign in_ch.ready = !stage_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stage.tick        <= in_ch.tick;
      stage.sleep_press <= in_ch.sleep_press;
      stage.up_press    <= in_ch.up_press;
      stage.down_press  <= in_ch.down_press;
      stage.reset_press <= in_ch.reset_press;
    end
  end

  bmc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bmc_core #(
    .TICKS_PER_SECOND   (TICKS_PER_SECOND),
    .HEARTBEAT_ON_TICKS (HEARTBEAT_ON_TICKS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (step),
    .item   (stage),
    .result (result)
  );

  bmc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (stage_valid),
    .result   (result),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  `BMC_ASSERT_NOW(a_err_dark, out_ch.valid && out_ch.fault_lamp, !out_ch.pump_led && !out_ch.horn_lamp)
  `BMC_ASSERT_NOW(a_blink_alt, out_ch.valid && out_ch.mode == bmc_pkg::MODE_BLINK, out_ch.pump_led ^ out_ch.horn_lamp)
  `BMC_ASSERT_NEXT(a_stage_hold, stage_valid && !can_load, stage_valid)
  `BMC_ASSERT_NEXT(a_step_out, step, out_ch.valid)

endmodule

// ===== bench/tb_blink_rate_mode_controller_top.sv =====
// Testbench for the blink rate mode controller: predicted indicator beats vs. the DUT.
`timescale 1ns / 1ps
module tb_blink_rate_mode_controller_top;

  localparam int unsigned CYCLE_LIMIT = 200000;

  class blink_scoreboard;
    localparam int unsigned TICKS_PER_SEC = 1000;
    localparam int unsigned HEARTBEAT_ON  = 250;

    bmc_pkg::cfg_t              cfg;
    bmc_pkg::mode_t             mode_q;
    logic [bmc_pkg::RATE_W-1:0] rate_q;
    logic [8:0]                 phase_q;
    logic [8:0]                 saved_q;
    logic                       lit_q;
    int unsigned                hb_q;
    bmc_pkg::result_t           expected_results[$];
    int unsigned                fails;

    function new();
      cfg.default_rate = bmc_pkg::DEFAULT_RATE_RESET;
      cfg.min_rate     = bmc_pkg::MIN_RATE_RESET;
      cfg.max_rate     = bmc_pkg::MAX_RATE_RESET;
      mode_q  = bmc_pkg::MODE_BLINK;
      rate_q  = bmc_pkg::DEFAULT_RATE_RESET;
      phase_q = half_period(bmc_pkg::DEFAULT_RATE_RESET);
      saved_q = '0;
      lit_q   = 1'b1;
      hb_q    = 0;
      fails   = 0;
    endfunction

    function logic [8:0] half_period(logic [bmc_pkg::RATE_W-1:0] r);
      int unsigned d;
      d = (r == 0) ? 1 : int'(r);
      return 9'((TICKS_PER_SEC / (2 * d)) & 'h1FF);
    endfunction

    function void resume_blink();
      mode_q  = bmc_pkg::MODE_BLINK;
      phase_q = saved_q;
    endfunction

    // buttons first, then the tick in the resulting mode
    function void note_beat(bmc_pkg::item_t it);
      int unsigned      low;
      int unsigned      r;
      bit               err;
      bmc_pkg::result_t want;
      low = (cfg.min_rate == 0) ? 1 : int'(cfg.min_rate);
      err = 1'b0;
      case (mode_q)
        bmc_pkg::MODE_BLINK: begin
          if (it.up_press) begin
            r = int'(rate_q) + 1;
            if (r > cfg.max_rate) err = 1'b1;
            rate_q = (r > bmc_pkg::RATE_TOP) ? bmc_pkg::RATE_TOP : bmc_pkg::RATE_W'(r);
          end
          if (!err && it.down_press) begin
            if (rate_q == 0 || int'(rate_q) - 1 < int'(low)) err = 1'b1;
            rate_q = (rate_q == 0) ? '0 : rate_q - 1'b1;
          end
          if (err) begin
            mode_q  = bmc_pkg::MODE_ERROR;
            saved_q = '0;
          end else begin
            if (it.up_press || it.down_press) phase_q = half_period(rate_q);
            if (it.reset_press) begin
              rate_q = cfg.default_rate;
              resume_blink();
            end else if (it.sleep_press) begin
              saved_q = phase_q;
              mode_q  = bmc_pkg::MODE_SLEEP;
            end
          end
        end
        bmc_pkg::MODE_SLEEP: begin
          if (it.reset_press) begin
            rate_q = cfg.default_rate;
            resume_blink();
          end else if (it.sleep_press) begin
            resume_blink();
          end
        end
        bmc_pkg::MODE_ERROR: begin
          if (it.reset_press) begin
            rate_q = cfg.default_rate;
            resume_blink();
          end
        end
        default: ;
      endcase
      if (it.tick) begin
        if (mode_q == bmc_pkg::MODE_BLINK) begin
          if (phase_q <= 1) begin
            lit_q   = ~lit_q;
            phase_q = half_period(rate_q);
          end else begin
            phase_q = phase_q - 1'b1;
          end
        end
        hb_q++;
        if (hb_q >= TICKS_PER_SEC) hb_q = 0;
      end
      want.pump_led   = (mode_q == bmc_pkg::MODE_BLINK) ? lit_q : 1'b0;
      want.horn_lamp  = (mode_q == bmc_pkg::MODE_BLINK) ? ~lit_q : 1'b0;
      want.fault_lamp = (mode_q == bmc_pkg::MODE_ERROR);
      want.pulse_lamp = (hb_q < HEARTBEAT_ON);
      want.mode       = mode_q;
      want.rate       = rate_q;
      expected_results.push_back(want);
    endfunction

    task flag_mismatch(string what);
      if (fails < 50) $display("MISMATCH: %s", what);
      fails++;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_beat(bmc_pkg::result_t got);
      bmc_pkg::result_t want;
      if (expected_results.size() == 0) begin
        flag_mismatch("output beat with nothing expected");
      end else begin
        want = expected_results.pop_front();
        compare_field("pump_led", got.pump_led, want.pump_led);
        compare_field("horn_lamp", got.horn_lamp, want.horn_lamp);
        compare_field("fault_lamp", got.fault_lamp, want.fault_lamp);
        compare_field("pulse_lamp", got.pulse_lamp, want.pulse_lamp);
        compare_field("mode", int'(got.mode), int'(want.mode));
        compare_field("rate", got.rate, want.rate);
      end
    endtask
  endclass

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [bmc_pkg::PADDR_W-1:0]  paddr;
  logic [bmc_pkg::PDATA_W-1:0]  pwdata;
  logic [bmc_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;
  int unsigned                  src_idle_pct;
  int unsigned                  sink_stall_pct;
  int unsigned                  cycle_count = 0;
  blink_scoreboard              sb;

  bmc_in_if  in_ch();
  bmc_out_if out_ch();

  blink_rate_mode_controller_top #(
    .TICKS_PER_SECOND   (1000),
    .HEARTBEAT_ON_TICKS (250)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // output side: random backpressure, check every accepted beat
  always @(posedge clk) begin
    bmc_pkg::result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.pump_led   = out_ch.pump_led;
      got.horn_lamp  = out_ch.horn_lamp;
      got.fault_lamp = out_ch.fault_lamp;
      got.pulse_lamp = out_ch.pulse_lamp;
      got.mode       = bmc_pkg::mode_t'(out_ch.mode);
      got.rate       = out_ch.rate;
      sb.check_beat(got);
    end
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic push_item(input bmc_pkg::item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.tick        <= it.tick;
    in_ch.sleep_press <= it.sleep_press;
    in_ch.up_press    <= it.up_press;
    in_ch.down_press  <= it.down_press;
    in_ch.reset_press <= it.reset_press;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_beat(it);
  endtask

  task automatic write_reg(input bmc_pkg::reg_idx_t idx,
                           input logic [bmc_pkg::RATE_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bmc_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= bmc_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      bmc_pkg::REG_DEFAULT_RATE: sb.cfg.default_rate = value;
      bmc_pkg::REG_MIN_RATE:     sb.cfg.min_rate = value;
      bmc_pkg::REG_MAX_RATE:     sb.cfg.max_rate = value;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic bmc_pkg::item_t mk_item(bit t, bit s, bit u, bit d, bit r);
    bmc_pkg::item_t it;
    it.tick        = t;
    it.sleep_press = s;
    it.up_press    = u;
    it.down_press  = d;
    it.reset_press = r;
    return it;
  endfunction

  // quiet tick runs, during which phases may expire, then short button bursts
  task automatic run_random(input int unsigned n_items);
    int unsigned    sent;
    int unsigned    quiet;
    int unsigned    burst;
    bmc_pkg::item_t it;
    sent = 0;
    while (sent < n_items) begin
      quiet = $urandom_range(300, 10);
      for (int i = 0; i < quiet && sent < n_items; i++) begin
        it      = '0;
        it.tick = ($urandom_range(9) != 0);
        push_item(it);
        sent++;
      end
      burst = $urandom_range(6, 1);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        it      = '0;
        it.tick = 1'($urandom_range(1));
        if ($urandom_range(3) == 0) begin
          {it.sleep_press, it.up_press, it.down_press, it.reset_press} = 4'($urandom);
        end else begin
          case ($urandom_range(3))
            0: it.sleep_press = 1'b1;
            1: it.up_press = 1'b1;
            2: it.down_press = 1'b1;
            default: it.reset_press = 1'b1;
          endcase
        end
        push_item(it);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [bmc_pkg::RATE_W-1:0] dflt,
                           input logic [bmc_pkg::RATE_W-1:0] lo,
                           input logic [bmc_pkg::RATE_W-1:0] hi, input int unsigned idle,
                           input int unsigned stall, input int unsigned n_items);
    drain();
    write_reg(bmc_pkg::REG_DEFAULT_RATE, dflt);
    write_reg(bmc_pkg::REG_MIN_RATE, lo);
    write_reg(bmc_pkg::REG_MAX_RATE, hi);
    src_idle_pct   = idle;
    sink_stall_pct = stall;
    run_random(n_items);
  endtask

  initial begin
    bmc_pkg::item_t directed[$];
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.tick         <= 1'b0;
    in_ch.sleep_press  <= 1'b0;
    in_ch.up_press     <= 1'b0;
    in_ch.down_press   <= 1'b0;
    in_ch.reset_press  <= 1'b0;
    sb             = new();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default rates 2 in 1..5
    directed = '{
      mk_item(0, 0, 0, 0, 0), mk_item(1, 0, 0, 0, 0), mk_item(0, 0, 1, 0, 0),
      mk_item(0, 0, 1, 1, 0), mk_item(1, 0, 1, 0, 0), mk_item(0, 0, 1, 0, 0),
      // above max: error wins over reset and sleep
      mk_item(1, 1, 1, 0, 1), mk_item(1, 0, 0, 0, 0), mk_item(0, 1, 1, 1, 0),
      mk_item(0, 0, 0, 0, 1), mk_item(1, 0, 0, 0, 0), mk_item(1, 1, 0, 0, 0),
      mk_item(1, 0, 1, 1, 0), mk_item(0, 1, 0, 0, 0), mk_item(1, 1, 0, 0, 0),
      mk_item(0, 1, 0, 0, 1), mk_item(0, 0, 0, 1, 0),
      // below min into rate 0
      mk_item(0, 0, 0, 1, 0), mk_item(1, 0, 0, 0, 1), mk_item(0, 1, 0, 0, 1),
      mk_item(0, 0, 1, 1, 0), mk_item(1, 1, 1, 1, 1)
    };
    foreach (directed[i]) push_item(directed[i]);
    in_ch.valid <= 1'b0;

    run_phase(4'd2, 4'd1, 4'd5, 0, 0, 250);
    run_phase(4'd14, 4'd1, 4'd14, 63, 0, 250);
    run_phase(4'd1, 4'd13, 4'd14, 0, 63, 250);
    run_phase(4'd14, 4'd1, 4'd2, 18, 18, 250);
    run_phase(4'd0, 4'd0, 4'd15, 0, 0, 200);
    run_phase(4'd7, 4'd3, 4'd9, 18, 18, 300);

    drain();
    repeat (10) @(posedge clk);
    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
